// File: rtl/core/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types, codes and character helpers of the framed ASCII command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

  localparam int BYTE_W        = 8;
  localparam int VAL_W         = 16;
  localparam int ACT_W         = 5;
  localparam int LIMIT_W       = 5;
  localparam int TABLE_W       = 38;
  localparam int TABLE_ENTRIES = 19;
  localparam int CNT_W         = 2;
  localparam int NUM_FIELDS    = 4;
  localparam int FIDX_W        = 3;
  localparam int FSEL_W        = 2;
  localparam int NUM_PARAMS    = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int STATUS_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_BYTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_TABLE    = 3'd4;

  localparam logic [BYTE_W-1:0]  START_BYTE_RST     = 8'd60;
  localparam logic [BYTE_W-1:0]  END_BYTE_RST       = 8'd62;
  localparam logic [BYTE_W-1:0]  SEPARATOR_BYTE_RST = 8'd44;
  localparam logic [LIMIT_W-1:0] ACTION_LIMIT_RST   = 5'd20;
  localparam logic [TABLE_W-1:0] PARAM_TABLE_RST    = 38'd1089077420;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_UNKNOWN_ACTION = 3'd1,
    ST_MISSING_PARAM  = 3'd2,
    ST_TOO_LONG       = 3'd3,
    ST_START_IN_FRAME = 3'd4
  } status_t;

  typedef struct packed {
    logic              feed;
    logic [BYTE_W-1:0] ch;
  } feed_t;

  typedef struct packed {
    logic [NUM_FIELDS-1:0]            present;
    logic [NUM_FIELDS-1:0][VAL_W-1:0] value;
  } fields_t;

  typedef struct packed {
    logic busy;
    logic done;
  } replay_status_t;

  typedef struct packed {
    status_t                          status;
    logic [ACT_W-1:0]                 action;
    logic [NUM_PARAMS-1:0][VAL_W-1:0] param;
  } result_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fac_field_scan.sv
// ----------------------------------------------------------------------------
// fac_field_scan
// Splits the frame body into fields and converts each one to a 16-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_field_scan #(
  parameter int FIELD_CHARS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clear,
  input  wire fac_pkg::feed_t  feed_in,
  input  wire logic [7:0]      separator_byte,
  input  wire logic [7:0]      end_byte,
  output fac_pkg::fields_t     fields
);

  import fac_pkg::*;

  localparam int NCHAR_W = $clog2(FIELD_CHARS + 1);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  logic [FIDX_W-1:0]  fidx;
  logic [NCHAR_W-1:0] nchar;
  phase_t             phase;
  logic               neg;
  logic [VAL_W-1:0]   acc;
  logic [NUM_FIELDS-1:0][VAL_W-1:0] val_q;
  logic [NUM_FIELDS-1:0]            pres_q;

  phase_t           phase_next;
  logic             neg_next;
  logic [VAL_W-1:0] acc_next;
  logic [VAL_W-1:0] cur_val;
  logic [VAL_W-1:0] digit;
  logic             active;
  logic             field_end;
  logic             take;

  assign cur_val   = neg ? VAL_W'(~acc + 1'b1) : acc;
  assign digit     = {{(VAL_W - 4){1'b0}}, feed_in.ch[3:0]};
  assign active    = feed_in.feed && (fidx < FIDX_W'(NUM_FIELDS));
  assign field_end = active && ((nchar == NCHAR_W'(FIELD_CHARS)) ||
                                (feed_in.ch == separator_byte) ||
                                (feed_in.ch == end_byte));
  assign take      = active && !field_end;

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    unique case (phase)
      PH_LEAD: begin
        if (is_space(feed_in.ch)) begin
          phase_next = PH_LEAD;
        end else if (feed_in.ch == CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = PH_DIGITS;
        end else if (feed_in.ch == CH_PLUS) begin
          phase_next = PH_DIGITS;
        end else if (is_digit(feed_in.ch)) begin
          acc_next   = digit;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(feed_in.ch)) begin
          acc_next = VAL_W'((acc << 3) + (acc << 1) + digit);
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fidx  <= '0;
      nchar <= '0;
      phase <= PH_LEAD;
      neg   <= 1'b0;
      acc   <= '0;
    end else if (field_end) begin
      val_q[fidx[FSEL_W-1:0]]  <= (nchar != '0) ? cur_val : '0;
      pres_q[fidx[FSEL_W-1:0]] <= (nchar != '0);
      fidx  <= fidx + 1'b1;
      nchar <= '0;
      phase <= PH_LEAD;
      neg   <= 1'b0;
      acc   <= '0;
    end else if (take) begin
      nchar <= nchar + 1'b1;
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (FIDX_W'(k) < fidx) begin
        fields.present[k] = pres_q[k];
        fields.value[k]   = val_q[k];
      end else if (FIDX_W'(k) == fidx) begin
        fields.present[k] = (nchar != '0);
        fields.value[k]   = (nchar != '0) ? cur_val : '0;
      end else begin
        fields.present[k] = 1'b0;
        fields.value[k]   = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fac_verdict.sv
// ----------------------------------------------------------------------------
// fac_verdict
// Checks the action and its parameters and forms the result of a closed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_verdict (
  input  wire fac_pkg::fields_t  fields,
  input  wire logic [4:0]        action_limit,
  input  wire logic [37:0]       param_count_table,
  output fac_pkg::result_t       result
);

  import fac_pkg::*;

  logic [VAL_W-1:0] v0;
  logic             act_ok;
  logic [ACT_W-1:0] act;
  logic [CNT_W-1:0] cnt;
  logic             missing;

  assign v0     = fields.value[0];
  assign act    = v0[ACT_W-1:0];
  assign act_ok = fields.present[0] && !v0[VAL_W-1] && (v0 != '0) &&
                  (v0 < {{(VAL_W - LIMIT_W){1'b0}}, action_limit});

  always_comb begin
    cnt = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      if (act == ACT_W'(e + 1)) begin
        cnt = param_count_table[2*e +: CNT_W];
      end
    end
  end

  always_comb begin
    missing = 1'b0;
    for (int k = 1; k <= NUM_PARAMS; k++) begin
      if ((CNT_W'(k) <= cnt) && !fields.present[k]) begin
        missing = 1'b1;
      end
    end
  end

  always_comb begin
    result = '0;
    if (!act_ok) begin
      result.status = ST_UNKNOWN_ACTION;
    end else if (missing) begin
      result.status = ST_MISSING_PARAM;
    end else begin
      result.status = ST_OK;
      result.action = act;
      for (int k = 1; k <= NUM_PARAMS; k++) begin
        result.param[k-1] = (CNT_W'(k) <= cnt) ? fields.value[k] : '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fac_replay.sv
// ----------------------------------------------------------------------------
// fac_replay
// Frame buffer and sequencer that feeds a stored frame body back to the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_replay #(
  parameter int FRAME_BYTES = 64,
  parameter int LEN_W       = $clog2(FRAME_BYTES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]                    wr_data,
  input  wire logic                          start,
  input  wire logic [LEN_W-1:0]              lim,
  input  wire logic                          ack,
  output fac_pkg::feed_t                     feed_out,
  output fac_pkg::replay_status_t            rp_status
);

  import fac_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [BYTE_W-1:0] mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_data;
  logic              rd_valid;
  logic              busy;
  logic [LEN_W-1:0]  addr;
  logic [LEN_W-1:0]  lim_q;
  logic              issue;
  logic              done;

  assign issue = busy && (addr < lim_q);
  assign done  = busy && !issue && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      rd_valid <= 1'b0;
      addr     <= LEN_W'(1);
      lim_q    <= lim;
    end else if (busy) begin
      rd_valid <= issue;
      if (issue) begin
        addr <= addr + 1'b1;
      end
      if (done && ack) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[addr[IDX_W-1:0]];
    end
  end

  assign feed_out.feed  = rd_valid;
  assign feed_out.ch    = rd_data;
  assign rp_status.busy = busy;
  assign rp_status.done = done;

endmodule

`default_nettype wire

// File: rtl/core/framed_ascii_command_parser.sv
// ----------------------------------------------------------------------------
// framed_ascii_command_parser
// Frames received bytes into messages and decodes an action with up to three
// signed decimal parameters from each message.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    rx_byte
// out       source     out_valid/out_stall  status, action, param_a..param_c
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A result is registered after
// the byte that closes or aborts its frame (input register, result register).
// A frame whose separator or end byte was rewritten while it was open is
// rescanned from the frame buffer when it closes, with the input stalled.
// Reset is synchronous; the frame buffer is not cleared and needs no sweep.
// Out stall holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_ascii_command_parser #(
  parameter int FRAME_BYTES = 64,
  parameter int FIELD_CHARS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [4:0]       action,
  output logic [15:0]      param_a,
  output logic [15:0]      param_b,
  output logic [15:0]      param_c,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [37:0] cfg_data
);

  import fac_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int LEN_W = $clog2(FRAME_BYTES + 1);

  logic [BYTE_W-1:0]  start_byte;
  logic [BYTE_W-1:0]  end_byte;
  logic [BYTE_W-1:0]  separator_byte;
  logic [LIMIT_W-1:0] action_limit;
  logic [TABLE_W-1:0] param_count_table;

  logic              pipe_valid;
  logic [BYTE_W-1:0] pipe_byte;
  logic              in_frame;
  logic              in_frame_next;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic              dirty;

  logic              out_free;
  logic              go;
  logic              cfg_write;
  logic              open_frame;
  logic              rp_start;
  logic              res_valid;
  result_t           res;
  result_t           res_frame;
  result_t           out_res;
  logic              wr_en;
  feed_t             pipe_feed;
  feed_t             rp_feed;
  feed_t             scan_feed;
  fields_t           fields;
  replay_status_t    rp_status;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign go        = pipe_valid && !rp_status.busy && out_free;
  assign in_stall  = pipe_valid && !go;
  assign scan_feed = rp_status.busy ? rp_feed : pipe_feed;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte        <= START_BYTE_RST;
      end_byte          <= END_BYTE_RST;
      separator_byte    <= SEPARATOR_BYTE_RST;
      action_limit      <= ACTION_LIMIT_RST;
      param_count_table <= PARAM_TABLE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_BYTE:     start_byte        <= cfg_data[BYTE_W-1:0];
        REG_END_BYTE:       end_byte          <= cfg_data[BYTE_W-1:0];
        REG_SEPARATOR_BYTE: separator_byte    <= cfg_data[BYTE_W-1:0];
        REG_ACTION_LIMIT:   action_limit      <= cfg_data[LIMIT_W-1:0];
        REG_PARAM_TABLE:    param_count_table <= cfg_data[TABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_frame_next  = in_frame;
    len_next       = len;
    open_frame     = 1'b0;
    rp_start       = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    wr_en          = 1'b0;
    pipe_feed.feed = 1'b0;
    pipe_feed.ch   = pipe_byte;
    if (go) begin
      priority if (pipe_byte == start_byte) begin
        if (!in_frame) begin
          in_frame_next = 1'b1;
          len_next      = LEN_W'(1);
          open_frame    = 1'b1;
        end else begin
          in_frame_next = 1'b0;
          len_next      = '0;
          res_valid     = 1'b1;
          res.status    = ST_START_IN_FRAME;
        end
      end else if (!in_frame) begin
        in_frame_next = 1'b0;
      end else if (pipe_byte == end_byte) begin
        in_frame_next = 1'b0;
        len_next      = '0;
        if (len < LEN_W'(FRAME_BYTES - 1)) begin
          if (dirty) begin
            rp_start = 1'b1;
          end else begin
            res_valid = 1'b1;
            res       = res_frame;
          end
        end else begin
          res_valid  = 1'b1;
          res.status = ST_TOO_LONG;
        end
      end else if (len < LEN_W'(FRAME_BYTES)) begin
        wr_en          = 1'b1;
        pipe_feed.feed = 1'b1;
        len_next       = len + 1'b1;
      end else begin
        in_frame_next = 1'b0;
        len_next      = '0;
        res_valid     = 1'b1;
        res.status    = ST_TOO_LONG;
      end
    end else if (rp_status.done && out_free) begin
      res_valid = 1'b1;
      res       = res_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
      in_frame   <= 1'b0;
      len        <= '0;
      dirty      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        pipe_valid <= in_valid;
      end
      in_frame <= in_frame_next;
      len      <= len_next;
      if (open_frame) begin
        dirty <= 1'b0;
      end else if (cfg_write && in_frame &&
                   ((cfg_index == REG_END_BYTE) || (cfg_index == REG_SEPARATOR_BYTE))) begin
        dirty <= 1'b1;
      end
      if (out_free) begin
        out_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pipe_byte <= rx_byte;
    end
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  fac_field_scan #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .clear         (open_frame || rp_start),
    .feed_in       (scan_feed),
    .separator_byte(separator_byte),
    .end_byte      (end_byte),
    .fields        (fields)
  );

  fac_verdict u_verdict (
    .fields           (fields),
    .action_limit     (action_limit),
    .param_count_table(param_count_table),
    .result           (res_frame)
  );

  fac_replay #(
    .FRAME_BYTES(FRAME_BYTES),
    .LEN_W      (LEN_W)
  ) u_replay (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (len[IDX_W-1:0]),
    .wr_data  (pipe_byte),
    .start    (rp_start),
    .lim      (len),
    .ack      (out_free),
    .feed_out (rp_feed),
    .rp_status(rp_status)
  );

  assign status  = out_res.status;
  assign action  = out_res.action;
  assign param_a = out_res.param[0];
  assign param_b = out_res.param[1];
  assign param_c = out_res.param[2];

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed ASCII command parser. Received bytes are
// sent as well-formed command frames with random fields, oversized frames,
// aborted frames and line noise, under several register settings. A
// scoreboard decodes each accepted byte on its own and checks every result
// transfer field by field, while the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import fac_pkg::*;

  class parser_scoreboard;
    localparam int FRAME_MAX = 64;
    localparam int FIELD_MAX = 8;

    logic [7:0]  start_b;
    logic [7:0]  end_b;
    logic [7:0]  sep_b;
    logic [4:0]  act_limit;
    logic [37:0] count_table;

    bit          open;
    int unsigned len;
    int unsigned scan_end;
    logic [7:0]  body [FRAME_MAX];
    result_t     expected_replies[$];
    int          errors;

    function new();
      start_b     = START_BYTE_RST;
      end_b       = END_BYTE_RST;
      sep_b       = SEPARATOR_BYTE_RST;
      act_limit   = ACTION_LIMIT_RST;
      count_table = PARAM_TABLE_RST;
      open        = 1'b0;
      len         = 0;
      scan_end    = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [37:0] val);
      case (idx)
        REG_START_BYTE:     start_b = val[7:0];
        REG_END_BYTE:       end_b = val[7:0];
        REG_SEPARATOR_BYTE: sep_b = val[7:0];
        REG_ACTION_LIMIT:   act_limit = val[4:0];
        REG_PARAM_TABLE:    count_table = val;
        default:            ;
      endcase
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void queue_fault(status_t st);
      result_t r;
      r = '0;
      r.status = st;
      expected_replies.push_back(r);
    endfunction

    // A field stops at a separator, an end byte, the frame end or after
    // eight characters; the parse then works like atoi with 16-bit wrap.
    function bit atoi_field(int unsigned s, int unsigned lim, output logic [15:0] val);
      int unsigned n;
      int unsigned p;
      bit          neg;
      n   = 0;
      neg = 1'b0;
      val = '0;
      while (n < FIELD_MAX && s + n < lim && body[s + n] != sep_b && body[s + n] != end_b)
        n++;
      scan_end = s + n;
      if (n == 0)
        return 1'b0;
      p = s;
      while (p < s + n && is_blank(body[p]))
        p++;
      if (p < s + n && body[p] == "-") begin
        neg = 1'b1;
        p++;
      end else if (p < s + n && body[p] == "+") begin
        p++;
      end
      while (p < s + n && body[p] >= "0" && body[p] <= "9") begin
        val = val * 16'd10 + 16'(body[p] - "0");
        p++;
      end
      if (neg)
        val = 16'd0 - val;
      return 1'b1;
    endfunction

    function void decode_frame();
      logic [15:0] val [4];
      bit          ok;
      bit          missing;
      int          act;
      int unsigned cnt;
      result_t     r;
      foreach (val[i])
        val[i] = '0;
      missing = 1'b0;
      ok = atoi_field(1, len, val[0]);
      act = int'($signed(val[0]));
      if (!ok || act <= 0 || act >= int'(act_limit)) begin
        queue_fault(ST_UNKNOWN_ACTION);
      end else begin
        cnt = int'((count_table >> (2 * (act - 1))) & 38'd3);
        for (int k = 1; k <= cnt; k++) begin
          if (!missing) begin
            ok = atoi_field(scan_end + 1, len, val[k]);
            if (!ok)
              missing = 1'b1;
          end
        end
        if (missing) begin
          queue_fault(ST_MISSING_PARAM);
        end else begin
          r = '0;
          r.status   = ST_OK;
          r.action   = act[4:0];
          r.param[0] = val[1];
          r.param[1] = val[2];
          r.param[2] = val[3];
          expected_replies.push_back(r);
        end
      end
    endfunction

    function void take_byte(logic [7:0] b);
      if (b == start_b) begin
        if (!open) begin
          open    = 1'b1;
          body[0] = b;
          len     = 1;
        end else begin
          open = 1'b0;
          len  = 0;
          queue_fault(ST_START_IN_FRAME);
        end
      end else if (open) begin
        if (b == end_b) begin
          open = 1'b0;
          if (len < FRAME_MAX - 1)
            decode_frame();
          else
            queue_fault(ST_TOO_LONG);
          len = 0;
        end else if (len < FRAME_MAX) begin
          body[len] = b;
          len++;
        end else begin
          open = 1'b0;
          len  = 0;
          queue_fault(ST_TOO_LONG);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_reply(logic [2:0] st, logic [4:0] act, logic [15:0] pa, pb, pc);
      result_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("result with status %0d and none expected", st));
      end else begin
        want = expected_replies.pop_front();
        compare("status", 16'(st), 16'(want.status));
        compare("action", 16'(act), 16'(want.action));
        compare("param_a", pa, want.param[0]);
        compare("param_b", pb, want.param[1]);
        compare("param_c", pc, want.param[2]);
      end
    endtask
  endclass

  localparam int ITEMS       = 550;
  localparam int PHASE_ITEMS = 60;
  localparam int SETTLE      = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic [7:0]  start_b;
    logic [7:0]  end_b;
    logic [7:0]  sep_b;
    logic [4:0]  limit;
    logic [37:0] counts;
  } setup_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [4:0]  action;
  logic [15:0] param_a;
  logic [15:0] param_b;
  logic [15:0] param_c;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [37:0] cfg_data  = '0;

  parser_scoreboard sb;
  setup_t           cur;
  logic [7:0]       tx_bytes[$];
  int               item_count  = 0;
  int               stuck_cycles = 0;
  bit               calm     = 1'b0;
  bit               hold_req = 1'b0;

  framed_ascii_command_parser u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .action(action),
    .param_a(param_a), .param_b(param_b), .param_c(param_c),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank();
    return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == cur.start_b || b == cur.end_b);
    return b;
  endfunction

  function automatic setup_t pick_setup(int phase);
    setup_t      s;
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    s.start_b = 8'($urandom_range(0, 255));
    s.end_b   = 8'($urandom_range(0, 255));
    s.sep_b   = 8'($urandom_range(0, 255));
    s.limit   = 5'($urandom_range(1, 20));
    s.counts  = w[37:0];
    case (phase)
      0: s = '{START_BYTE_RST, END_BYTE_RST, SEPARATOR_BYTE_RST, ACTION_LIMIT_RST,
               PARAM_TABLE_RST};
      1: s = '{8'h00, 8'hFF, 8'h2C, 5'd1, 38'd0};
      2: s = '{8'hFF, 8'h00, 8'h2C, 5'd20, {38{1'b1}}};
      3: begin
        s.start_b = "[";
        s.end_b   = "]";
        s.sep_b   = 8'h00;
      end
      4: begin
        s.start_b = "{";
        s.end_b   = "}";
        s.sep_b   = 8'hFF;
        s.limit   = 5'd20;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic put_reg(input logic [2:0] idx, input logic [37:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setup(input setup_t s);
    put_reg(REG_START_BYTE, 38'(s.start_b));
    put_reg(REG_END_BYTE, 38'(s.end_b));
    put_reg(REG_SEPARATOR_BYTE, 38'(s.sep_b));
    put_reg(REG_ACTION_LIMIT, 38'(s.limit));
    put_reg(REG_PARAM_TABLE, s.counts);
    cfg_valid <= 1'b0;
    cur = s;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
  endtask

  task automatic send_stream(input bit counted);
    if (counted)
      item_count += tx_bytes.size();
    while (tx_bytes.size() > 0)
      send_byte(tx_bytes.pop_front());
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++)
      tx_bytes.push_back(t[i]);
  endtask

  task automatic add_field();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r >= 8 && r < 16) begin
      n = $urandom_range(9, 14);
      for (int k = 0; k < n; k++)
        tx_bytes.push_back(8'($urandom_range(48, 57)));
    end else if (r >= 16 && r < 24) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++)
        tx_bytes.push_back(8'($urandom_range(33, 126)));
    end else if (r >= 24) begin
      n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++)
        tx_bytes.push_back(blank());
      r = $urandom_range(0, 9);
      if (r < 3)
        tx_bytes.push_back("-");
      else if (r < 5)
        tx_bytes.push_back("+");
      add_text($sformatf("%0d", $urandom_range(0, (r > 6) ? 99999 : 999)));
    end
  endtask

  task automatic build_command();
    int act;
    int cnt;
    tx_bytes.push_back(cur.start_b);
    if ($urandom_range(0, 99) < 80 && cur.limit > 1) begin
      act = $urandom_range(1, cur.limit - 1);
      if ($urandom_range(0, 9) == 0)
        tx_bytes.push_back(blank());
      add_text($sformatf("%0d", act));
      cnt = int'((cur.counts >> (2 * (act - 1))) & 38'd3);
    end else begin
      add_field();
      cnt = $urandom_range(0, 3);
    end
    if ($urandom_range(0, 99) < 15)
      cnt = $urandom_range(0, 3);
    for (int k = 0; k < cnt; k++) begin
      tx_bytes.push_back(cur.sep_b);
      add_field();
    end
    tx_bytes.push_back(cur.end_b);
  endtask

  task automatic build_oversized();
    int n;
    n = $urandom_range(60, 70);
    tx_bytes.push_back(cur.start_b);
    for (int k = 0; k < n; k++)
      tx_bytes.push_back(plain_byte());
    tx_bytes.push_back(cur.end_b);
  endtask

  task automatic build_aborted();
    int n;
    n = $urandom_range(0, 6);
    tx_bytes.push_back(cur.start_b);
    for (int k = 0; k < n; k++)
      tx_bytes.push_back(plain_byte());
    tx_bytes.push_back(cur.start_b);
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      if (r < 70)
        build_command();
      else if (r < 78)
        build_oversized();
      else
        build_aborted();
      send_stream(1'b1);
    end else begin
      for (int k = $urandom_range(1, 5); k > 0; k--)
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      send_stream(1'b0);
    end
  endtask

  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = idle_len();
        out_stall <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply(status, action, param_a, param_b, param_c);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int goal;
    sb  = new();
    cur = pick_setup(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Line noise at both byte extremes, then a start inside a frame, an empty
    // action, a bare action, a missing parameter and a sign-only field.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    add_text("<<<><1><3,-1,><2,-0,+,9>");
    send_stream(1'b1);

    phase = 0;
    while (item_count < ITEMS) begin
      wait_replies();
      apply_setup(pick_setup(phase));
      calm = (phase % 3 == 1);
      if (phase == 2)
        hold_req = 1'b1;
      goal = item_count + PHASE_ITEMS;
      while (item_count < goal)
        random_frame();
      phase++;
    end
    wait_replies();

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// File: framed_ascii_command_parser.f
rtl/core/fac_pkg.sv
rtl/core/fac_field_scan.sv
rtl/core/fac_verdict.sv
rtl/core/fac_replay.sv
rtl/core/framed_ascii_command_parser.sv
dv/tb_top.sv
